// ----- rtl/ecnd_pkg.sv -----
// ----------------------------------------------------------------------------
// ecnd_pkg
// Shared types, constants and helpers for the extremum nearest-colour
// denoise core.
// ----------------------------------------------------------------------------
package ecnd_pkg;

   // frame geometry
   localparam int SIDE_BITS = 8;
   localparam int MAX_SIDE  = 256;
   localparam int ADDR_BITS = 2 * SIDE_BITS;
   localparam int SIZE_BITS = 9;

   // pixel format
   localparam int CHAN_BITS = 8;
   localparam int CHANNELS  = 3;
   localparam int PIX_BITS  = CHANNELS * CHAN_BITS;
   localparam int SQ_BITS   = 2 * CHAN_BITS;
   localparam int MAG_BITS  = 18;   // 3 * 255^2 = 195075 fits
   localparam int NCH_BITS  = 2;

   // window
   localparam int MASK_SIDE  = 5;
   localparam int MASK_HALF  = 2;
   localparam int MASK_TAPS  = MASK_SIDE * MASK_SIDE;
   localparam int MAX_RADIUS = 2;
   localparam int RAD_BITS   = 2;
   localparam int POS_BITS   = 5;
   localparam int AXIS_BITS  = 3;

   // register port
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH  = 3'd0,
      REG_IMAGE_HEIGHT = 3'd1,
      REG_CHANNEL_CNT  = 3'd2,
      REG_RADIUS_ROWS  = 3'd3,
      REG_RADIUS_COLS  = 3'd4,
      REG_WINDOW_MASK  = 3'd5
   } csr_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } seq_state_type;

   typedef enum logic [1:0] {
      SLOT_NONE,
      SLOT_CENTRE,
      SLOT_NEIGH
   } slot_kind_type;

   // effective (clamped) configuration
   typedef struct packed {
      logic [SIZE_BITS-1:0] width;
      logic [SIZE_BITS-1:0] height;
      logic [NCH_BITS-1:0]  nch;
      logic [RAD_BITS-1:0]  rad_rows;
      logic [RAD_BITS-1:0]  rad_cols;
      logic [MASK_TAPS-1:0] mask;
   } cfg_type;

   // one pixel after the metric unit
   typedef struct packed {
      slot_kind_type        kind;
      logic [PIX_BITS-1:0]  pix;
      logic [MAG_BITS-1:0]  mag;
      logic [MAG_BITS-1:0]  sqdist;
   } metric_type;

   function automatic logic [SIZE_BITS-1:0] clamp_side(input logic [SIZE_BITS-1:0] v);
      logic [SIZE_BITS-1:0] r;
      if (v == '0) begin
         r = SIZE_BITS'(1);
      end else if (v > SIZE_BITS'(MAX_SIDE)) begin
         r = SIZE_BITS'(MAX_SIDE);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [RAD_BITS-1:0] clamp_radius(input logic [RAD_BITS-1:0] v);
      logic [RAD_BITS-1:0] r;
      r = v;
      if (r > RAD_BITS'(MASK_HALF)) begin
         r = RAD_BITS'(MASK_HALF);
      end
      if (r > RAD_BITS'(MAX_RADIUS)) begin
         r = RAD_BITS'(MAX_RADIUS);
      end
      return r;
   endfunction

   function automatic logic [NCH_BITS-1:0] used_channels(input logic [NCH_BITS-1:0] v);
      logic [NCH_BITS-1:0] r;
      r = v;
      if (r == '0) begin
         r = NCH_BITS'(1);
      end
      if (r > NCH_BITS'(CHANNELS)) begin
         r = NCH_BITS'(CHANNELS);
      end
      return r;
   endfunction

endpackage

// ----- rtl/ecnd_frame_mem.sv -----
// ----------------------------------------------------------------------------
// ecnd_frame_mem
// Frame store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ecnd_frame_mem (
   input  logic                           clock,
   input  logic                           we,
   input  logic [ecnd_pkg::ADDR_BITS-1:0] waddr,
   input  logic [ecnd_pkg::PIX_BITS-1:0]  wdata,
   input  logic [ecnd_pkg::ADDR_BITS-1:0] raddr,
   output logic [ecnd_pkg::PIX_BITS-1:0]  rd_data_ff
);

   logic [ecnd_pkg::PIX_BITS-1:0] mem [0:(1 << ecnd_pkg::ADDR_BITS)-1];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read port, one read per cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[raddr];
   end

endmodule

// ----- rtl/ecnd_metric_unit.sv -----
// ----------------------------------------------------------------------------
// ecnd_metric_unit
// Shared arithmetic: magnitude of a pixel and squared colour distance to the
// centre over the channels in use, one pixel per cycle, registered.
// ----------------------------------------------------------------------------
module ecnd_metric_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ecnd_pkg::NCH_BITS-1:0] nch,
   input  ecnd_pkg::slot_kind_type       kind,
   input  logic [ecnd_pkg::PIX_BITS-1:0] pix,
   input  logic [ecnd_pkg::PIX_BITS-1:0] centre,
   output ecnd_pkg::metric_type          metric
);

   logic [ecnd_pkg::CHAN_BITS-1:0] a_val;
   logic [ecnd_pkg::CHAN_BITS-1:0] b_val;
   logic [ecnd_pkg::CHAN_BITS-1:0] diff;
   logic [ecnd_pkg::SQ_BITS-1:0]   sq_a;
   logic [ecnd_pkg::SQ_BITS-1:0]   sq_d;
   logic [ecnd_pkg::MAG_BITS-1:0]  mag_in;
   logic [ecnd_pkg::MAG_BITS-1:0]  dist_in;
   ecnd_pkg::slot_kind_type        kind_ff;
   logic [ecnd_pkg::PIX_BITS-1:0]  pix_ff;
   logic [ecnd_pkg::MAG_BITS-1:0]  mag_ff;
   logic [ecnd_pkg::MAG_BITS-1:0]  dist_ff;

   // per-channel squares, summed over the channels in use
   always_comb begin
      mag_in  = '0;
      dist_in = '0;
      a_val   = '0;
      b_val   = '0;
      diff    = '0;
      sq_a    = '0;
      sq_d    = '0;
      for (int k = 0; k < ecnd_pkg::CHANNELS; k++) begin
         a_val = pix[k*ecnd_pkg::CHAN_BITS +: ecnd_pkg::CHAN_BITS];
         b_val = centre[k*ecnd_pkg::CHAN_BITS +: ecnd_pkg::CHAN_BITS];
         diff  = (a_val > b_val) ? (a_val - b_val) : (b_val - a_val);
         sq_a  = {{ecnd_pkg::CHAN_BITS{1'b0}}, a_val} * {{ecnd_pkg::CHAN_BITS{1'b0}}, a_val};
         sq_d  = {{ecnd_pkg::CHAN_BITS{1'b0}}, diff} * {{ecnd_pkg::CHAN_BITS{1'b0}}, diff};
         if (ecnd_pkg::NCH_BITS'(k) < nch) begin
            mag_in  = mag_in + ecnd_pkg::MAG_BITS'(sq_a);
            dist_in = dist_in + ecnd_pkg::MAG_BITS'(sq_d);
         end
      end
   end

   // slot tag
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= ecnd_pkg::SLOT_NONE;
      end else begin
         kind_ff <= kind;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      pix_ff  <= pix;
      mag_ff  <= mag_in;
      dist_ff <= dist_in;
   end

   assign metric.kind   = kind_ff;
   assign metric.pix    = pix_ff;
   assign metric.mag    = mag_ff;
   assign metric.sqdist = dist_ff;

endmodule

// ----- rtl/ecnd_seq.sv -----
// ----------------------------------------------------------------------------
// ecnd_seq
// Sequencer: takes transactions, walks the 5x5 window one read per cycle,
// keeps the extremum flags and the nearest neighbour, drives the result.
// ----------------------------------------------------------------------------
module ecnd_seq (
   input  logic                           clock,
   input  logic                           reset,
   input  ecnd_pkg::cfg_type              cfg,
   input  logic                           start,
   input  logic                           req_op,
   input  logic [ecnd_pkg::SIDE_BITS-1:0] req_row,
   input  logic [ecnd_pkg::SIDE_BITS-1:0] req_col,
   input  logic [ecnd_pkg::PIX_BITS-1:0]  req_pix,
   output logic                           busy,
   output logic                           mem_we,
   output logic [ecnd_pkg::ADDR_BITS-1:0] mem_waddr,
   output logic [ecnd_pkg::PIX_BITS-1:0]  mem_wdata,
   output logic [ecnd_pkg::ADDR_BITS-1:0] mem_raddr,
   input  logic [ecnd_pkg::PIX_BITS-1:0]  rd_data,
   output ecnd_pkg::slot_kind_type        slot_kind,
   output logic [ecnd_pkg::PIX_BITS-1:0]  centre_pix,
   input  ecnd_pkg::metric_type           metric,
   output logic                           rsp_valid,
   output logic [ecnd_pkg::PIX_BITS-1:0]  rsp_pix,
   output logic                           rsp_replaced
);

   localparam int ROW_EXT = ecnd_pkg::SIZE_BITS + 1;

   ecnd_pkg::seq_state_type        state_ff, state_in;
   logic [ecnd_pkg::SIDE_BITS-1:0] row_ff, row_in;
   logic [ecnd_pkg::SIDE_BITS-1:0] col_ff, col_in;
   logic [ecnd_pkg::AXIS_BITS-1:0] prow_ff, prow_in;
   logic [ecnd_pkg::AXIS_BITS-1:0] pcol_ff, pcol_in;
   logic [ecnd_pkg::POS_BITS-1:0]  pos_ff, pos_in;
   logic                           drain_ff, drain_in;
   logic                           outside_ff, outside_in;
   ecnd_pkg::slot_kind_type        slot_ff, slot_in;
   logic [ecnd_pkg::PIX_BITS-1:0]  centre_ff, centre_in;
   logic [ecnd_pkg::MAG_BITS-1:0]  cmag_ff, cmag_in;
   logic                           hi_ff, hi_in;
   logic                           lo_ff, lo_in;
   logic                           found_ff, found_in;
   logic [ecnd_pkg::MAG_BITS-1:0]  bestd_ff, bestd_in;
   logic [ecnd_pkg::PIX_BITS-1:0]  best_ff, best_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [ecnd_pkg::PIX_BITS-1:0]  rsp_pix_ff, rsp_pix_in;
   logic                           rsp_replaced_ff, rsp_replaced_in;

   logic                 accept;
   logic                 scan;
   logic                 finish;
   logic [ROW_EXT-1:0]   r_pos;
   logic [ROW_EXT-1:0]   c_pos;
   logic                 r_ok;
   logic                 c_ok;
   logic                 dr_ok;
   logic                 dc_ok;
   logic                 not_centre;
   logic                 neigh_valid;
   logic                 new_hi;
   logic                 new_lo;

   assign accept = start && !busy;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ecnd_pkg::ST_IDLE: begin
            if (accept && req_op) begin
               state_in = ecnd_pkg::ST_SCAN;
            end
         end
         ecnd_pkg::ST_SCAN: begin
            if (pos_ff == ecnd_pkg::POS_BITS'(ecnd_pkg::MASK_TAPS - 1)) begin
               state_in = ecnd_pkg::ST_DRAIN;
            end
         end
         ecnd_pkg::ST_DRAIN: begin
            if (drain_ff) begin
               state_in = ecnd_pkg::ST_FINISH;
            end
         end
         ecnd_pkg::ST_FINISH: begin
            state_in = ecnd_pkg::ST_IDLE;
         end
         default: begin
            state_in = ecnd_pkg::ST_IDLE;
         end
      endcase
   end

   // state decode
   always_comb begin
      busy   = 1'b1;
      scan   = 1'b0;
      finish = 1'b0;
      unique case (state_ff)
         ecnd_pkg::ST_IDLE:   busy   = 1'b0;
         ecnd_pkg::ST_SCAN:   scan   = 1'b1;
         ecnd_pkg::ST_DRAIN:  busy   = 1'b1;
         ecnd_pkg::ST_FINISH: finish = 1'b1;
         default:             busy   = 1'b1;
      endcase
   end

   // window position check
   always_comb begin
      r_pos = {2'b00, row_ff} + {{(ROW_EXT-ecnd_pkg::AXIS_BITS){1'b0}}, prow_ff}
              - ROW_EXT'(ecnd_pkg::MASK_HALF);
      c_pos = {2'b00, col_ff} + {{(ROW_EXT-ecnd_pkg::AXIS_BITS){1'b0}}, pcol_ff}
              - ROW_EXT'(ecnd_pkg::MASK_HALF);
      r_ok  = !r_pos[ROW_EXT-1] && (r_pos[ecnd_pkg::SIZE_BITS-1:0] < cfg.height);
      c_ok  = !c_pos[ROW_EXT-1] && (c_pos[ecnd_pkg::SIZE_BITS-1:0] < cfg.width);
      dr_ok = ({1'b0, prow_ff} + {2'b00, cfg.rad_rows}) >= 4'(ecnd_pkg::MASK_HALF) &&
              prow_ff <= (3'(ecnd_pkg::MASK_HALF) + {1'b0, cfg.rad_rows});
      dc_ok = ({1'b0, pcol_ff} + {2'b00, cfg.rad_cols}) >= 4'(ecnd_pkg::MASK_HALF) &&
              pcol_ff <= (3'(ecnd_pkg::MASK_HALF) + {1'b0, cfg.rad_cols});
      not_centre  = !(prow_ff == 3'(ecnd_pkg::MASK_HALF) &&
                      pcol_ff == 3'(ecnd_pkg::MASK_HALF));
      neigh_valid = r_ok && c_ok && dr_ok && dc_ok && not_centre &&
                    cfg.mask[pos_ff] && !outside_ff;
   end

   // memory ports: centre read at accept, then one window tap per cycle
   assign mem_we    = accept && !req_op;
   assign mem_waddr = {req_row, req_col};
   assign mem_wdata = req_pix;
   assign mem_raddr = scan ? {r_pos[ecnd_pkg::SIDE_BITS-1:0], c_pos[ecnd_pkg::SIDE_BITS-1:0]}
                           : {req_row, req_col};

   // address walk
   always_comb begin
      row_in     = row_ff;
      col_in     = col_ff;
      prow_in    = prow_ff;
      pcol_in    = pcol_ff;
      pos_in     = pos_ff;
      drain_in   = drain_ff;
      outside_in = outside_ff;
      slot_in    = ecnd_pkg::SLOT_NONE;
      if (accept && req_op) begin
         row_in     = req_row;
         col_in     = req_col;
         prow_in    = '0;
         pcol_in    = '0;
         pos_in     = '0;
         drain_in   = 1'b0;
         outside_in = ({1'b0, req_row} >= cfg.height) || ({1'b0, req_col} >= cfg.width);
         slot_in    = ecnd_pkg::SLOT_CENTRE;
      end else if (scan) begin
         pos_in  = pos_ff + 1'b1;
         slot_in = neigh_valid ? ecnd_pkg::SLOT_NEIGH : ecnd_pkg::SLOT_NONE;
         if (pcol_ff == 3'(ecnd_pkg::MASK_SIDE - 1)) begin
            pcol_in = '0;
            prow_in = prow_ff + 1'b1;
         end else begin
            pcol_in = pcol_ff + 1'b1;
         end
      end else if (state_ff == ecnd_pkg::ST_DRAIN) begin
         drain_in = 1'b1;
      end
   end

   // centre capture as its read data arrives
   assign centre_in  = (slot_ff == ecnd_pkg::SLOT_CENTRE) ? rd_data : centre_ff;
   assign slot_kind  = slot_ff;
   assign centre_pix = centre_ff;

   // extremum flags and nearest neighbour
   always_comb begin
      cmag_in  = cmag_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      found_in = found_ff;
      bestd_in = bestd_ff;
      best_in  = best_ff;
      new_hi   = hi_ff && (metric.mag < cmag_ff);
      new_lo   = lo_ff && (metric.mag > cmag_ff);
      if (accept && req_op) begin
         hi_in    = 1'b1;
         lo_in    = 1'b1;
         found_in = 1'b0;
      end else if (metric.kind == ecnd_pkg::SLOT_CENTRE) begin
         cmag_in = metric.mag;
      end else if (metric.kind == ecnd_pkg::SLOT_NEIGH) begin
         hi_in = new_hi;
         lo_in = new_lo;
         if ((new_hi || new_lo) && (!found_ff || metric.sqdist < bestd_ff)) begin
            found_in = 1'b1;
            bestd_in = metric.sqdist;
            best_in  = metric.pix;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in    = 1'b0;
      rsp_pix_in      = rsp_pix_ff;
      rsp_replaced_in = 1'b0;
      if (accept && !req_op) begin
         rsp_valid_in = 1'b1;
         rsp_pix_in   = '0;
      end else if (finish) begin
         rsp_valid_in = 1'b1;
         if (found_ff && (hi_ff || lo_ff)) begin
            rsp_pix_in      = best_ff;
            rsp_replaced_in = 1'b1;
         end else begin
            rsp_pix_in = centre_ff;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ecnd_pkg::ST_IDLE;
         slot_ff         <= ecnd_pkg::SLOT_NONE;
         drain_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         rsp_replaced_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         slot_ff         <= slot_in;
         drain_ff        <= drain_in;
         rsp_valid_ff    <= rsp_valid_in;
         rsp_replaced_ff <= rsp_replaced_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      row_ff     <= row_in;
      col_ff     <= col_in;
      prow_ff    <= prow_in;
      pcol_ff    <= pcol_in;
      pos_ff     <= pos_in;
      outside_ff <= outside_in;
      centre_ff  <= centre_in;
      cmag_ff    <= cmag_in;
      hi_ff      <= hi_in;
      lo_ff      <= lo_in;
      found_ff   <= found_in;
      bestd_ff   <= bestd_in;
      best_ff    <= best_in;
      rsp_pix_ff <= rsp_pix_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_pix      = rsp_pix_ff;
   assign rsp_replaced = rsp_replaced_ff;

   // checks
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff == ecnd_pkg::ST_FINISH) || $past(accept && !req_op)))
      else $error("result strobe without a finished transaction");

   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op) |=> (state_ff == ecnd_pkg::ST_SCAN && slot_ff == ecnd_pkg::SLOT_CENTRE))
      else $error("query did not start with the centre read");

   a_replaced_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_replaced_ff |-> rsp_valid_ff)
      else $error("replaced flag outside a result");

   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ecnd_pkg::ST_SCAN) |->
         (pos_ff < 5'(ecnd_pkg::MASK_TAPS) && prow_ff < 3'(ecnd_pkg::MASK_SIDE) &&
          pcol_ff < 3'(ecnd_pkg::MASK_SIDE)))
      else $error("window walk out of range");

   a_neigh_in_query: assert property (@(posedge clock) disable iff (reset)
      (metric.kind == ecnd_pkg::SLOT_NEIGH) |->
         (state_ff == ecnd_pkg::ST_SCAN || state_ff == ecnd_pkg::ST_DRAIN))
      else $error("neighbour data outside a query");

endmodule

// ----- rtl/extremum_nearest_color_denoise_core.sv -----
// ----------------------------------------------------------------------------
// extremum_nearest_color_denoise_core
// Frame store with an extremum nearest-colour denoise query.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel: a transaction is taken when start is high and busy low.
//    req_op 0 writes req_in_chan0..2 at (req_row, req_col); req_op 1 queries
//    the pixel at (req_row, req_col).
//  - Result channel: rsp_valid marks each result for one cycle; the receiver
//    must take it then, there is no back-pressure.
//  - A write answers (all zero) in the cycle after it is taken; busy stays
//    low, so writes can follow back to back, one per cycle.
//  - A query reads the centre and then all 25 window taps from the frame
//    memory, one read per cycle through its single read port; the metric
//    unit and the compare stage follow the reads. Busy is high while the
//    query runs and drops as its result appears.
//  - Configuration: APB registers at byte addresses 0x00..0x14, written
//    only while idle (the block itself does not enforce this); pready is always high.
//  - Reset clears control state and loads the register defaults; the frame
//    memory is not cleared and must be written before it is queried.
// ----------------------------------------------------------------------------
module extremum_nearest_color_denoise_core (
   input  logic                               clock,
   input  logic                               reset,
   // input channel
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_op,
   input  logic [7:0]                         req_row,
   input  logic [7:0]                         req_col,
   input  logic [7:0]                         req_in_chan0,
   input  logic [7:0]                         req_in_chan1,
   input  logic [7:0]                         req_in_chan2,
   // result channel
   output logic                               rsp_valid,
   output logic [7:0]                         rsp_out_chan0,
   output logic [7:0]                         rsp_out_chan1,
   output logic [7:0]                         rsp_out_chan2,
   output logic                               rsp_replaced,
   // register port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [ecnd_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [ecnd_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [ecnd_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                               pready
);

   logic [ecnd_pkg::SIZE_BITS-1:0] width_ff, width_in;
   logic [ecnd_pkg::SIZE_BITS-1:0] height_ff, height_in;
   logic [ecnd_pkg::NCH_BITS-1:0]  nch_ff, nch_in;
   logic [ecnd_pkg::RAD_BITS-1:0]  rad_rows_ff, rad_rows_in;
   logic [ecnd_pkg::RAD_BITS-1:0]  rad_cols_ff, rad_cols_in;
   logic [ecnd_pkg::MASK_TAPS-1:0] mask_ff, mask_in;

   logic                           csr_write;
   ecnd_pkg::csr_reg_type          csr_index;
   ecnd_pkg::cfg_type              cfg;

   logic                           mem_we;
   logic [ecnd_pkg::ADDR_BITS-1:0] mem_waddr;
   logic [ecnd_pkg::PIX_BITS-1:0]  mem_wdata;
   logic [ecnd_pkg::ADDR_BITS-1:0] mem_raddr;
   logic [ecnd_pkg::PIX_BITS-1:0]  rd_data;
   ecnd_pkg::slot_kind_type        slot_kind;
   logic [ecnd_pkg::PIX_BITS-1:0]  centre_pix;
   ecnd_pkg::metric_type           metric;
   logic [ecnd_pkg::PIX_BITS-1:0]  rsp_pix;

   // register write decode
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = ecnd_pkg::csr_reg_type'(paddr[4:2]);

   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      nch_in      = nch_ff;
      rad_rows_in = rad_rows_ff;
      rad_cols_in = rad_cols_ff;
      mask_in     = mask_ff;
      if (csr_write) begin
         unique case (csr_index)
            ecnd_pkg::REG_IMAGE_WIDTH:  width_in    = pwdata[ecnd_pkg::SIZE_BITS-1:0];
            ecnd_pkg::REG_IMAGE_HEIGHT: height_in   = pwdata[ecnd_pkg::SIZE_BITS-1:0];
            ecnd_pkg::REG_CHANNEL_CNT:  nch_in      = pwdata[ecnd_pkg::NCH_BITS-1:0];
            ecnd_pkg::REG_RADIUS_ROWS:  rad_rows_in = pwdata[ecnd_pkg::RAD_BITS-1:0];
            ecnd_pkg::REG_RADIUS_COLS:  rad_cols_in = pwdata[ecnd_pkg::RAD_BITS-1:0];
            ecnd_pkg::REG_WINDOW_MASK:  mask_in     = pwdata[ecnd_pkg::MASK_TAPS-1:0];
            default:                    mask_in     = mask_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= ecnd_pkg::SIZE_BITS'(ecnd_pkg::MAX_SIDE);
         height_ff   <= ecnd_pkg::SIZE_BITS'(ecnd_pkg::MAX_SIDE);
         nch_ff      <= ecnd_pkg::NCH_BITS'(ecnd_pkg::CHANNELS);
         rad_rows_ff <= ecnd_pkg::RAD_BITS'(1);
         rad_cols_ff <= ecnd_pkg::RAD_BITS'(1);
         mask_ff     <= '1;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         nch_ff      <= nch_in;
         rad_rows_ff <= rad_rows_in;
         rad_cols_ff <= rad_cols_in;
         mask_ff     <= mask_in;
      end
   end

   // read back
   always_comb begin
      prdata = '0;
      unique case (csr_index)
         ecnd_pkg::REG_IMAGE_WIDTH:  prdata = ecnd_pkg::CSR_DATA_BITS'(width_ff);
         ecnd_pkg::REG_IMAGE_HEIGHT: prdata = ecnd_pkg::CSR_DATA_BITS'(height_ff);
         ecnd_pkg::REG_CHANNEL_CNT:  prdata = ecnd_pkg::CSR_DATA_BITS'(nch_ff);
         ecnd_pkg::REG_RADIUS_ROWS:  prdata = ecnd_pkg::CSR_DATA_BITS'(rad_rows_ff);
         ecnd_pkg::REG_RADIUS_COLS:  prdata = ecnd_pkg::CSR_DATA_BITS'(rad_cols_ff);
         ecnd_pkg::REG_WINDOW_MASK:  prdata = ecnd_pkg::CSR_DATA_BITS'(mask_ff);
         default:                    prdata = '0;
      endcase
   end

   // effective settings
   assign cfg.width    = ecnd_pkg::clamp_side(width_ff);
   assign cfg.height   = ecnd_pkg::clamp_side(height_ff);
   assign cfg.nch      = ecnd_pkg::used_channels(nch_ff);
   assign cfg.rad_rows = ecnd_pkg::clamp_radius(rad_rows_ff);
   assign cfg.rad_cols = ecnd_pkg::clamp_radius(rad_cols_ff);
   assign cfg.mask     = mask_ff;

   ecnd_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .start        (start),
      .req_op       (req_op),
      .req_row      (req_row),
      .req_col      (req_col),
      .req_pix      ({req_in_chan2, req_in_chan1, req_in_chan0}),
      .busy         (busy),
      .mem_we       (mem_we),
      .mem_waddr    (mem_waddr),
      .mem_wdata    (mem_wdata),
      .mem_raddr    (mem_raddr),
      .rd_data      (rd_data),
      .slot_kind    (slot_kind),
      .centre_pix   (centre_pix),
      .metric       (metric),
      .rsp_valid    (rsp_valid),
      .rsp_pix      (rsp_pix),
      .rsp_replaced (rsp_replaced)
   );

   ecnd_frame_mem u_frame_mem (
      .clock      (clock),
      .we         (mem_we),
      .waddr      (mem_waddr),
      .wdata      (mem_wdata),
      .raddr      (mem_raddr),
      .rd_data_ff (rd_data)
   );

   ecnd_metric_unit u_metric (
      .clock  (clock),
      .reset  (reset),
      .nch    (cfg.nch),
      .kind   (slot_kind),
      .pix    (rd_data),
      .centre (centre_pix),
      .metric (metric)
   );

   assign rsp_out_chan0 = rsp_pix[7:0];
   assign rsp_out_chan1 = rsp_pix[15:8];
   assign rsp_out_chan2 = rsp_pix[23:16];

endmodule
